/* design/ts_pmt_section_parser_macros.svh */
// Assertion helpers for the PMT section parser. Both sample on clk and
// stand down while arst_n is low.
`ifndef TS_PMT_SECTION_PARSER_MACROS_SVH
`define TS_PMT_SECTION_PARSER_MACROS_SVH

// Same-cycle implication.
`define TS_PMT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define TS_PMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ts_pmt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ts_pmt_pkg;

	// Fixed section layout
	localparam int PROGRAM_FIXED_BYTES       = 4;
	localparam int STREAM_FIXED_BYTES        = 5;
	localparam int HEADER_AFTER_LENGTH_BYTES = 5;
	localparam int CRC_BYTES                 = 4;
	localparam int LOOP_OVERHEAD             =
		HEADER_AFTER_LENGTH_BYTES + CRC_BYTES + PROGRAM_FIXED_BYTES;

	// Parse phases
	localparam logic [2:0] PH_IDLE  = 3'd0;
	localparam logic [2:0] PH_PFIX  = 3'd1;
	localparam logic [2:0] PH_PDESC = 3'd2;
	localparam logic [2:0] PH_SFIX  = 3'd3;
	localparam logic [2:0] PH_EDESC = 3'd4;
	localparam logic [2:0] PH_DONE  = 3'd5;

	// Descriptor walk position
	localparam logic [2:0] DS_TAG  = 3'd0;
	localparam logic [2:0] DS_LEN  = 3'd1;
	localparam logic [2:0] DS_BODY = 3'd2;

	// Record kinds
	localparam logic [1:0] KIND_PROGRAM = 2'd0;
	localparam logic [1:0] KIND_STREAM  = 2'd1;
	localparam logic [1:0] KIND_END     = 2'd2;
	localparam logic [1:0] KIND_ERROR   = 2'd3;

	// Error codes
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_SHORT     = 2'd1;
	localparam logic [1:0] ERR_OVERRUN   = 2'd2;
	localparam logic [1:0] ERR_BAD_DESC  = 2'd3;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        first_byte;
		logic [11:0] section_len;
	} pmt_byte_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [7:0]  es_type;
		logic [12:0] pid_value;
		logic [11:0] info_length;
		logic [1:0]  error_code;
		logic        section_done;
	} pmt_record_t;

endpackage

`default_nettype wire

/* design/ts_pmt_section_parser.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "ts_pmt_section_parser_macros.svh"

// PMT section parser. Feed the data part of a program map section (the bytes
// after the five header bytes that follow the section length field) one item
// per byte, with first_byte set and the section length valid on the first
// byte; first_byte may arrive at any time and abandons the section in
// progress. The block
// emits a program record (PCR PID, program info length) on the fourth byte,
// one stream record (stream type, elementary PID, ES info length) on the fifth
// byte of each stream entry, a section-end record when an ES descriptor byte
// closes the stream loop, and an error record (kind 3) for a loop that is too
// short, a stream entry that overruns the loop, or a descriptor that runs past
// its region. Error records and the loop-closing record carry section_done;
// after them, and after the loop in general (the CRC), bytes are dropped until
// the next first_byte. Descriptor contents are skipped, not reported.
// Rate: one byte per clock while records are taken; a record blocked behind
// a full output register stalls input. A byte is registered on accept and
// parsed in the following cycle by a single update of the parse registers,
// which waits while its record is blocked; records go out on rec_valid.
// byte_ready only drops while a parsed byte that yields a record waits behind
// a full output register that is not being taken.
module ts_pmt_section_parser (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      byte_valid,
	output logic                     byte_ready,
	input  wire ts_pmt_pkg::pmt_byte_t byte_data,
	output logic                     rec_valid,
	input  wire                      rec_ready,
	output ts_pmt_pkg::pmt_record_t  rec_data
);
	import ts_pmt_pkg::*;

	// Input register
	logic        valid_s1;
	pmt_byte_t   in_s1;

	// Parse state
	logic [2:0]  phase_q;
	logic [2:0]  fbi_q;
	logic [12:0] pil_q;        // program info bytes left
	logic [13:0] sll_q;        // stream loop bytes left
	logic [12:0] esl_q;        // ES info bytes left
	logic [7:0]  desc_q;       // descriptor body bytes left
	logic [7:0]  stype_q;
	logic [12:0] pid_q;
	logic [11:0] len_q;
	logic [11:0] sl_q;

	// Output register
	logic        rec_valid_q;
	pmt_record_t rec_q;

	// Effective state for this byte: first_byte restarts the section
	logic [2:0]  cur_phase;
	logic [2:0]  cur_fbi;
	logic [11:0] cur_sl;
	logic [7:0]  b;
	logic [11:0] len_full;
	logic [12:0] pid_full;
	logic signed [13:0] loop_len;
	logic [12:0] need;

	// Descriptor walk, shared by both descriptor regions
	logic [12:0] reg_left;
	logic [12:0] walk_left;
	logic [7:0]  walk_desc;
	logic [2:0]  walk_fbi;
	logic        walk_bad;
	logic        walk_end;

	// Next state and result
	logic [2:0]  nxt_phase;
	logic [2:0]  nxt_fbi;
	logic [12:0] nxt_pil;
	logic [13:0] nxt_sll;
	logic [12:0] nxt_esl;
	logic [7:0]  nxt_desc;
	logic [7:0]  nxt_stype;
	logic [12:0] nxt_pid;
	logic [11:0] nxt_len;
	logic        emit;
	pmt_record_t res;
	logic        adv;

	assign cur_phase = in_s1.first_byte ? PH_PFIX : phase_q;
	assign cur_fbi   = in_s1.first_byte ? DS_TAG : fbi_q;
	assign cur_sl    = in_s1.first_byte ? in_s1.section_len : sl_q;
	assign b         = in_s1.data_byte;
	assign len_full  = {len_q[11:8], b};
	assign pid_full  = {pid_q[12:8], b};
	assign loop_len  = $signed({2'b00, cur_sl}) - $signed({2'b00, len_full})
		- 14'(LOOP_OVERHEAD);
	assign need      = 13'(STREAM_FIXED_BYTES) + {1'b0, len_full};
	assign reg_left  = (cur_phase == PH_PDESC) ? pil_q : esl_q;

	// One step of a tag/length walk through a descriptor region
	always_comb begin
		walk_left = reg_left - 13'd1;
		walk_desc = desc_q;
		walk_fbi  = cur_fbi;
		walk_bad  = 1'b0;
		walk_end  = 1'b0;
		case (cur_fbi)
			DS_TAG: begin
				walk_bad = (reg_left < 13'd2);
				walk_fbi = DS_LEN;
			end
			DS_LEN: begin
				walk_bad  = ({5'b0, b} > walk_left);
				walk_desc = b;
				walk_fbi  = (b != 8'd0) ? DS_BODY : DS_TAG;
				walk_end  = (walk_left == 13'd0);
			end
			default: begin
				walk_bad  = (reg_left == 13'd0) || (desc_q == 8'd0);
				walk_desc = desc_q - 8'd1;
				walk_fbi  = (walk_desc == 8'd0) ? DS_TAG : cur_fbi;
				walk_end  = (walk_left == 13'd0);
			end
		endcase
	end

	// Parse one byte
	always_comb begin
		nxt_phase = cur_phase;
		nxt_fbi   = cur_fbi;
		nxt_pil   = pil_q;
		nxt_sll   = sll_q;
		nxt_esl   = esl_q;
		nxt_desc  = desc_q;
		nxt_stype = stype_q;
		nxt_pid   = pid_q;
		nxt_len   = len_q;
		emit      = 1'b0;
		res       = '0;
		case (cur_phase)
			PH_PFIX: begin
				nxt_fbi = cur_fbi + 3'd1;
				case (cur_fbi)
					3'd0: nxt_pid = {b[4:0], 8'h00};
					3'd1: nxt_pid = pid_full;
					3'd2: nxt_len = {b[3:0], 8'h00};
					default: begin
						nxt_len = len_full;
						emit    = 1'b1;
						if (loop_len < $signed(14'(STREAM_FIXED_BYTES))) begin
							nxt_phase        = PH_DONE;
							res.record_kind  = KIND_ERROR;
							res.error_code   = ERR_SHORT;
							res.section_done = 1'b1;
						end else begin
							nxt_sll         = loop_len;
							nxt_pil         = {1'b0, len_full};
							nxt_fbi         = DS_TAG;
							nxt_phase       = (len_full != 12'd0) ? PH_PDESC : PH_SFIX;
							res.record_kind = KIND_PROGRAM;
							res.pid_value   = pid_q;
							res.info_length = len_full;
						end
					end
				endcase
			end
			PH_PDESC, PH_EDESC: begin
				nxt_desc = walk_desc;
				nxt_fbi  = walk_fbi;
				if (cur_phase == PH_PDESC) begin
					nxt_pil = walk_left;
				end else begin
					nxt_esl = walk_left;
				end
				if (walk_bad) begin
					emit             = 1'b1;
					nxt_phase        = PH_DONE;
					res.record_kind  = KIND_ERROR;
					res.error_code   = ERR_BAD_DESC;
					res.section_done = 1'b1;
				end else if (walk_end) begin
					nxt_fbi = DS_TAG;
					if (cur_phase == PH_EDESC && sll_q == 14'd0) begin
						emit             = 1'b1;
						nxt_phase        = PH_DONE;
						res.record_kind  = KIND_END;
						res.section_done = 1'b1;
					end else begin
						nxt_phase = PH_SFIX;
					end
				end
			end
			PH_SFIX: begin
				nxt_fbi = cur_fbi + 3'd1;
				case (cur_fbi)
					3'd0: nxt_stype = b;
					3'd1: nxt_pid   = {b[4:0], 8'h00};
					3'd2: nxt_pid   = pid_full;
					3'd3: nxt_len   = {b[3:0], 8'h00};
					default: begin
						nxt_len = len_full;
						emit    = 1'b1;
						if ({1'b0, need} > sll_q) begin
							nxt_phase        = PH_DONE;
							res.record_kind  = KIND_ERROR;
							res.error_code   = ERR_OVERRUN;
							res.section_done = 1'b1;
						end else begin
							nxt_sll          = sll_q - {1'b0, need};
							nxt_esl          = {1'b0, len_full};
							nxt_fbi          = DS_TAG;
							res.record_kind  = KIND_STREAM;
							res.es_type      = stype_q;
							res.pid_value    = pid_q;
							res.info_length  = len_full;
							res.section_done = (len_full == 12'd0) && (nxt_sll == 14'd0);
							if (len_full != 12'd0) begin
								nxt_phase = PH_EDESC;
							end else if (nxt_sll == 14'd0) begin
								nxt_phase = PH_DONE;
							end else begin
								nxt_phase = PH_SFIX;
							end
						end
					end
				endcase
			end
			default: begin
				// idle or done: drop the byte
			end
		endcase
	end

	// Advance the parsed byte unless its record has nowhere to go
	assign adv        = valid_s1 && (!emit || !rec_valid_q || rec_ready);
	assign byte_ready = !valid_s1 || adv;
	assign rec_valid  = rec_valid_q;
	assign rec_data   = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rec_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			fbi_q       <= DS_TAG;
			pil_q       <= '0;
			sll_q       <= '0;
			esl_q       <= '0;
			desc_q      <= '0;
			stype_q     <= '0;
			pid_q       <= '0;
			len_q       <= '0;
			sl_q        <= '0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (adv && emit) begin
				rec_valid_q <= 1'b1;
			end else if (rec_ready) begin
				rec_valid_q <= 1'b0;
			end
			if (adv) begin
				phase_q <= nxt_phase;
				fbi_q   <= nxt_fbi;
				pil_q   <= nxt_pil;
				sll_q   <= nxt_sll;
				esl_q   <= nxt_esl;
				desc_q  <= nxt_desc;
				stype_q <= nxt_stype;
				pid_q   <= nxt_pid;
				len_q   <= nxt_len;
				sl_q    <= cur_sl;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			in_s1 <= byte_data;
		end
		if (adv && emit) begin
			rec_q <= res;
		end
	end

	`TS_PMT_ASSERT_NOW(a_err_closes, rec_valid && rec_data.record_kind == KIND_ERROR, rec_data.section_done && rec_data.error_code != ERR_NONE, "error record without section_done or code")
	`TS_PMT_ASSERT_NOW(a_code_only_err, rec_valid && rec_data.record_kind != KIND_ERROR, rec_data.error_code == ERR_NONE, "error code on a non-error record")
	`TS_PMT_ASSERT_NEXT(a_hold_blocked, valid_s1 && emit && rec_valid_q && !rec_ready, valid_s1 && $stable(in_s1), "blocked byte lost")
	`TS_PMT_ASSERT_NEXT(a_done_phase, adv && emit && res.section_done, phase_q == PH_DONE, "section_done without entering done phase")

endmodule

`default_nettype wire
